// ===== design/fltpm_pkg.sv =====
// Package: shared types and constants of the four-level page table manager.
`timescale 1ns / 1ps

package fltpm_pkg;

   localparam int TABLE_PAGES       = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int FRAME_BITS        = 40;

   localparam int INDEX_W  = $clog2(ENTRIES_PER_TABLE);
   localparam int PAGE_W   = $clog2(TABLE_PAGES);
   localparam int NF_W     = $clog2(TABLE_PAGES + 1);
   localparam int ADDR_W   = PAGE_W + INDEX_W;
   localparam int DEPTH    = TABLE_PAGES * ENTRIES_PER_TABLE;
   localparam int ENTRY_W  = 42;
   localparam int VPN_W    = 36;
   localparam int RESULT_W = 40;

   localparam logic [1:0] CMD_MAP   = 2'd0;
   localparam logic [1:0] CMD_WALK  = 2'd1;
   localparam logic [1:0] CMD_UNMAP = 2'd2;
   localparam logic [1:0] CMD_REMAP = 2'd3;

   localparam logic [1:0] ST_DONE        = 2'd0;
   localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
   localparam logic [1:0] ST_POOL_EMPTY  = 2'd2;

   localparam logic [1:0] SEL_ZERO = 2'd0;
   localparam logic [1:0] SEL_LEAF = 2'd1;
   localparam logic [1:0] SEL_VPN  = 2'd2;

   localparam logic [1:0] LEAF_LEVEL = 2'd3;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [VPN_W-1:0] virt_page;
      logic [39:0]      frame;
      logic [VPN_W-1:0] target_virt_page;
   } req_type;

   typedef struct packed {
      logic [RESULT_W-1:0] result_page;
      logic [1:0]          status;
   } rsp_type;

   typedef struct packed {
      logic       load_req;
      logic       clear_wr;
      logic       mem_rd;
      logic       descend;
      logic       switch_target;
      logic       unmap_wr;
      logic       clr_old_wr;
      logic       build_wr;
      logic       respond;
      logic [1:0] rsp_status;
      logic [1:0] rsp_sel;
   } ctl_type;

   typedef struct packed {
      logic       clear_done;
      logic       child_ok;
      logic       leaf_zero;
      logic       pool_ok;
      logic       phase;
      logic [1:0] level;
      logic [1:0] cmd;
   } sts_type;

endpackage

// ===== design/four_level_page_table_manager.sv =====
// Top level: four-level page table manager, controller plus datapath.
// Per item the controller reads and checks one entry per table level; walk and unmap stop
// early when a level is absent; map adds up to 4 writes; remap walks both pages.
// One item at a time: the next is taken as the result shows.
// rsp_valid pulses once per item and the receiver cannot stall it.
// After reset a clearing pass over all TABLE_PAGES * 512 entries (32768) holds busy.
`timescale 1ns / 1ps

module four_level_page_table_manager (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  fltpm_pkg::req_type req_item,
   output fltpm_pkg::rsp_type rsp_item,
   output logic               rsp_valid
);

   fltpm_pkg::ctl_type ctl;
   fltpm_pkg::sts_type sts;

   fltpm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy)
   );

   fltpm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid)
   );

endmodule

// ===== design/fltpm_datapath.sv =====
// Datapath: table store, walk registers, bump allocator and result register.
`timescale 1ns / 1ps

module fltpm_datapath (
   input  logic               clock,
   input  logic               reset,
   input  fltpm_pkg::req_type req_item,
   input  fltpm_pkg::ctl_type ctl,
   output fltpm_pkg::sts_type sts,
   output fltpm_pkg::rsp_type rsp_item,
   output logic               rsp_valid
);

   logic [fltpm_pkg::ENTRY_W-1:0] mem [fltpm_pkg::DEPTH];
   logic [fltpm_pkg::ENTRY_W-1:0] rdata_ff;

   logic [1:0]                       cmd_ff, cmd_in;
   logic [fltpm_pkg::VPN_W-1:0]      vpn_sel_ff, vpn_sel_in;
   logic [fltpm_pkg::VPN_W-1:0]      target_ff, target_in;
   logic [fltpm_pkg::FRAME_BITS-1:0] frame_ff, frame_in;
   logic [fltpm_pkg::PAGE_W-1:0]     page_ff, page_in;
   logic [1:0]                       level_ff, level_in;
   logic                             phase_ff, phase_in;
   logic [fltpm_pkg::ADDR_W-1:0]     old_slot_ff, old_slot_in;
   logic [fltpm_pkg::NF_W-1:0]       next_free_ff, next_free_in;
   logic [fltpm_pkg::ADDR_W-1:0]     clr_cnt_ff, clr_cnt_in;
   fltpm_pkg::rsp_type               rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic [fltpm_pkg::INDEX_W-1:0]    idx;
   logic [fltpm_pkg::ADDR_W-1:0]     walk_addr;
   logic [fltpm_pkg::ADDR_W-1:0]     mem_addr;
   logic [fltpm_pkg::ENTRY_W-1:0]    mem_wdata;
   logic                             mem_we;
   logic [fltpm_pkg::NF_W-1:0]       avail;
   logic [fltpm_pkg::NF_W-1:0]       needed;

   always_comb begin
      case (level_ff)
         2'd0:    idx = vpn_sel_ff[35:27];
         2'd1:    idx = vpn_sel_ff[26:18];
         2'd2:    idx = vpn_sel_ff[17:9];
         default: idx = vpn_sel_ff[8:0];
      endcase
   end

   assign walk_addr = {page_ff, idx};

   always_comb begin
      mem_we    = ctl.clear_wr | ctl.unmap_wr | ctl.clr_old_wr | ctl.build_wr;
      mem_wdata = '0;
      if (ctl.clear_wr) begin
         mem_addr = clr_cnt_ff;
      end else if (ctl.clr_old_wr) begin
         mem_addr = old_slot_ff;
      end else begin
         mem_addr = walk_addr;
      end
      if (ctl.build_wr) begin
         if (level_ff != fltpm_pkg::LEAF_LEVEL) begin
            mem_wdata = {40'(next_free_ff), 2'b11};
         end else begin
            mem_wdata = {40'(frame_ff), 2'b11};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (ctl.mem_rd) begin
         rdata_ff <= mem[mem_addr];
      end
   end

   assign avail  = fltpm_pkg::NF_W'(fltpm_pkg::TABLE_PAGES) - next_free_ff;
   assign needed = fltpm_pkg::NF_W'(fltpm_pkg::LEAF_LEVEL - level_ff);

   always_comb begin
      sts.clear_done = (clr_cnt_ff == fltpm_pkg::ADDR_W'(fltpm_pkg::DEPTH - 1));
      sts.child_ok   = rdata_ff[0] && (rdata_ff[41:2] < 40'(fltpm_pkg::TABLE_PAGES));
      sts.leaf_zero  = (rdata_ff[fltpm_pkg::FRAME_BITS+1:2] == '0);
      sts.pool_ok    = (needed <= avail);
      sts.phase      = phase_ff;
      sts.level      = level_ff;
      sts.cmd        = cmd_ff;
   end

   always_comb begin
      cmd_in       = cmd_ff;
      vpn_sel_in   = vpn_sel_ff;
      target_in    = target_ff;
      frame_in     = frame_ff;
      page_in      = page_ff;
      level_in     = level_ff;
      phase_in     = phase_ff;
      old_slot_in  = old_slot_ff;
      next_free_in = next_free_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = ctl.respond;
      if (ctl.clear_wr && !sts.clear_done) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      if (ctl.load_req) begin
         cmd_in     = req_item.cmd;
         vpn_sel_in = req_item.virt_page;
         target_in  = req_item.target_virt_page;
         frame_in   = req_item.frame[fltpm_pkg::FRAME_BITS-1:0];
         page_in    = '0;
         level_in   = '0;
         phase_in   = 1'b0;
      end
      if (ctl.descend) begin
         page_in  = rdata_ff[fltpm_pkg::PAGE_W+1:2];
         level_in = level_ff + 1'b1;
      end
      if (ctl.switch_target) begin
         old_slot_in = walk_addr;
         frame_in    = rdata_ff[fltpm_pkg::FRAME_BITS+1:2];
         vpn_sel_in  = target_ff;
         page_in     = '0;
         level_in    = '0;
         phase_in    = 1'b1;
      end
      if (ctl.build_wr && level_ff != fltpm_pkg::LEAF_LEVEL) begin
         page_in      = next_free_ff[fltpm_pkg::PAGE_W-1:0];
         next_free_in = next_free_ff + 1'b1;
         level_in     = level_ff + 1'b1;
      end
      if (ctl.respond) begin
         rsp_in.status = ctl.rsp_status;
         case (ctl.rsp_sel)
            fltpm_pkg::SEL_LEAF:
               rsp_in.result_page =
                  fltpm_pkg::RESULT_W'(rdata_ff[fltpm_pkg::FRAME_BITS+1:2]);
            fltpm_pkg::SEL_VPN:
               rsp_in.result_page = fltpm_pkg::RESULT_W'(vpn_sel_ff);
            default:
               rsp_in.result_page = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         level_ff     <= '0;
         next_free_ff <= fltpm_pkg::NF_W'(1);
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         next_free_ff <= next_free_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      vpn_sel_ff  <= vpn_sel_in;
      target_ff   <= target_in;
      frame_ff    <= frame_in;
      page_ff     <= page_in;
      old_slot_ff <= old_slot_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_item  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= fltpm_pkg::NF_W'(fltpm_pkg::TABLE_PAGES))
      else $error("allocator beyond pool");

   a_alloc_room: assert property (@(posedge clock) disable iff (reset)
      (ctl.build_wr && level_ff != fltpm_pkg::LEAF_LEVEL)
         |-> next_free_ff < fltpm_pkg::NF_W'(fltpm_pkg::TABLE_PAGES))
      else $error("table allocated from empty pool");

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.clear_wr, ctl.unmap_wr, ctl.clr_old_wr, ctl.build_wr}))
      else $error("conflicting table writes");

endmodule

// ===== design/fltpm_ctrl.sv =====
// Controller: state machine sequencing clearing, walks and table builds.
`timescale 1ns / 1ps

module fltpm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  fltpm_pkg::sts_type sts,
   output fltpm_pkg::ctl_type ctl,
   output logic               busy
);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_READ    = 3'd2;
   localparam logic [2:0] S_CHECK   = 3'd3;
   localparam logic [2:0] S_CLR_OLD = 3'd4;
   localparam logic [2:0] S_BUILD   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       needs_build;
   logic [2:0] build_entry;

   assign needs_build = (sts.cmd == fltpm_pkg::CMD_MAP) ||
                        (sts.cmd == fltpm_pkg::CMD_REMAP && sts.phase);
   assign build_entry = (sts.cmd == fltpm_pkg::CMD_REMAP) ? S_CLR_OLD : S_BUILD;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            ctl.clear_wr = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               ctl.load_req = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            ctl.mem_rd = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            if (sts.level != fltpm_pkg::LEAF_LEVEL) begin
               if (sts.child_ok) begin
                  ctl.descend = 1'b1;
                  state_in    = S_READ;
               end else if (needs_build && sts.pool_ok) begin
                  state_in = build_entry;
               end else begin
                  ctl.respond    = 1'b1;
                  ctl.rsp_sel    = fltpm_pkg::SEL_ZERO;
                  ctl.rsp_status = needs_build ? fltpm_pkg::ST_POOL_EMPTY
                                               : fltpm_pkg::ST_NOT_PRESENT;
                  state_in       = S_IDLE;
               end
            end else if (needs_build) begin
               state_in = build_entry;
            end else begin
               case (sts.cmd)
                  fltpm_pkg::CMD_WALK: begin
                     ctl.respond    = 1'b1;
                     ctl.rsp_sel    = fltpm_pkg::SEL_LEAF;
                     ctl.rsp_status = fltpm_pkg::ST_DONE;
                     state_in       = S_IDLE;
                  end
                  fltpm_pkg::CMD_UNMAP: begin
                     ctl.unmap_wr   = 1'b1;
                     ctl.respond    = 1'b1;
                     ctl.rsp_sel    = fltpm_pkg::SEL_ZERO;
                     ctl.rsp_status = fltpm_pkg::ST_DONE;
                     state_in       = S_IDLE;
                  end
                  fltpm_pkg::CMD_REMAP: begin
                     if (sts.leaf_zero) begin
                        ctl.respond    = 1'b1;
                        ctl.rsp_sel    = fltpm_pkg::SEL_ZERO;
                        ctl.rsp_status = fltpm_pkg::ST_NOT_PRESENT;
                        state_in       = S_IDLE;
                     end else begin
                        ctl.switch_target = 1'b1;
                        state_in          = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CLR_OLD: begin
            ctl.clr_old_wr = 1'b1;
            state_in       = S_BUILD;
         end
         S_BUILD: begin
            ctl.build_wr = 1'b1;
            if (sts.level == fltpm_pkg::LEAF_LEVEL) begin
               ctl.respond    = 1'b1;
               ctl.rsp_sel    = fltpm_pkg::SEL_VPN;
               ctl.rsp_status = fltpm_pkg::ST_DONE;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   a_resp_ends_item: assert property (@(posedge clock) disable iff (reset)
      ctl.respond |=> state_ff == S_IDLE)
      else $error("item not closed after response");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.load_req |=> busy)
      else $error("busy not raised after accepting an item");

   a_clear_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !ctl.load_req && !ctl.respond)
      else $error("item handled during clearing pass");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the page table manager: directed table, then random commands.
`timescale 1ns / 1ps
module tb_top;
   import fltpm_pkg::*;

   localparam int STALL_LIMIT  = 150000;
   localparam int DRAIN_CYCLES = 60;
   localparam int MAX_GAP      = 30;
   localparam int PHASE_ITEMS  = 175;
   localparam logic [VPN_W-1:0] VPN_ONES   = '1;
   localparam logic [39:0]      FRAME_ONES = '1;
   localparam logic [39:0]      FRAME_KEEP = 40'((41'd1 << FRAME_BITS) - 41'd1);

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type rsp;
   } plan_row;

   logic    clock;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   rsp_type rsp_item;
   logic    rsp_valid;

   four_level_page_table_manager dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid)
   );

   // shadow page tables
   bit [ENTRY_W-1:0]   page_store [DEPTH];
   int unsigned        next_table = 1;
   rsp_type            pending_rsp [$];
   logic [VPN_W-1:0]   live_pages [$];
   logic [INDEX_W-1:0] hot_index [4][3];
   plan_row            plan [$];
   rsp_type            oldest_rsp;
   int                 send_idle_pct = 0;
   int                 mismatches    = 0;
   int                 idle_cycles   = 0;
   int                 cmd_seen [4];
   int                 status_seen [4];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned level_slot(logic [VPN_W-1:0] vpn, int lv);
      return int'((vpn >> (INDEX_W * (3 - lv))) & (ENTRIES_PER_TABLE - 1));
   endfunction

   function automatic bit follow_entry(bit [ENTRY_W-1:0] e, output int unsigned pg);
      bit [39:0] a;
      a  = e[ENTRY_W-1:2];
      pg = 0;
      if (!e[0] || a >= TABLE_PAGES) return 1'b0;
      pg = int'(a);
      return 1'b1;
   endfunction

   function automatic bit find_leaf_slot(logic [VPN_W-1:0] vpn, output int unsigned slot,
                                         output int missing);
      int unsigned pg;
      int unsigned nxt;
      pg      = 0;
      slot    = 0;
      missing = 0;
      for (int lv = 0; lv < 3; lv++) begin
         if (!follow_entry(page_store[pg * ENTRIES_PER_TABLE + level_slot(vpn, lv)], nxt)) begin
            missing = lv;
            return 1'b0;
         end
         pg = nxt;
      end
      slot = pg * ENTRIES_PER_TABLE + level_slot(vpn, 3);
      return 1'b1;
   endfunction

   function automatic int unsigned tables_missing(logic [VPN_W-1:0] vpn);
      int unsigned slot;
      int          missing;
      if (find_leaf_slot(vpn, slot, missing)) return 0;
      return 3 - missing;
   endfunction

   function automatic bit pool_covers(int unsigned n);
      return TABLE_PAGES >= next_table && n <= TABLE_PAGES - next_table;
   endfunction

   function automatic void install_leaf(logic [VPN_W-1:0] vpn, logic [39:0] frame);
      int unsigned pg;
      int unsigned pos;
      int unsigned nxt;
      pg = 0;
      for (int lv = 0; lv < 3; lv++) begin
         pos = pg * ENTRIES_PER_TABLE + level_slot(vpn, lv);
         if (!follow_entry(page_store[pos], nxt)) begin
            nxt = next_table;
            next_table++;
            for (int k = 0; k < ENTRIES_PER_TABLE; k++)
               page_store[nxt * ENTRIES_PER_TABLE + k] = '0;
            page_store[pos] = (ENTRY_W'(nxt) << 2) | ENTRY_W'(3);
         end
         pg = nxt;
      end
      page_store[pg * ENTRIES_PER_TABLE + level_slot(vpn, 3)] =
         (ENTRY_W'(frame & FRAME_KEEP) << 2) | ENTRY_W'(3);
   endfunction

   function automatic rsp_type predict_page_op(req_type r);
      rsp_type     o;
      int unsigned slot;
      int          missing;
      logic [39:0] old;
      o   = '0;
      old = '0;
      case (r.cmd)
         CMD_MAP: begin
            if (!pool_covers(tables_missing(r.virt_page))) begin
               o.status = ST_POOL_EMPTY;
            end else begin
               install_leaf(r.virt_page, r.frame);
               o.result_page = RESULT_W'(r.virt_page);
            end
         end
         CMD_WALK: begin
            if (find_leaf_slot(r.virt_page, slot, missing))
               o.result_page = page_store[slot][ENTRY_W-1:2] & FRAME_KEEP;
            else
               o.status = ST_NOT_PRESENT;
         end
         CMD_UNMAP: begin
            if (find_leaf_slot(r.virt_page, slot, missing))
               page_store[slot] = '0;
            else
               o.status = ST_NOT_PRESENT;
         end
         default: begin
            if (find_leaf_slot(r.virt_page, slot, missing))
               old = page_store[slot][ENTRY_W-1:2] & FRAME_KEEP;
            if (old == 0) begin
               o.status = ST_NOT_PRESENT;
            end else if (!pool_covers(tables_missing(r.target_virt_page))) begin
               o.status = ST_POOL_EMPTY;
            end else begin
               page_store[slot] = '0;
               install_leaf(r.target_virt_page, old);
               o.result_page = RESULT_W'(r.target_virt_page);
            end
         end
      endcase
      return o;
   endfunction

   function automatic void add_row(logic [1:0] c, logic [VPN_W-1:0] v, logic [39:0] f,
                                   logic [VPN_W-1:0] t, logic typed, logic [39:0] page,
                                   logic [1:0] st);
      plan_row row;
      row.req.cmd              = c;
      row.req.virt_page        = v;
      row.req.frame            = f;
      row.req.target_virt_page = t;
      row.typed                = typed;
      row.rsp.result_page      = page;
      row.rsp.status           = st;
      plan.push_back(row);
   endfunction

   function automatic logic [VPN_W-1:0] pick_page(int wide_pct);
      logic [VPN_W-1:0] v;
      if ($urandom_range(99) < wide_pct) return VPN_W'({$urandom, $urandom});
      for (int lv = 0; lv < 4; lv++)
         v[INDEX_W*(3-lv) +: INDEX_W] = hot_index[lv][$urandom_range(2)];
      if ($urandom_range(3) == 0) v[INDEX_W-1:0] = INDEX_W'($urandom);
      return v;
   endfunction

   function automatic req_type random_op(int wide_pct);
      req_type r;
      int      pick;
      int      reuse_pct;
      pick  = $urandom_range(99);
      r.cmd = pick < 35 ? CMD_MAP : pick < 65 ? CMD_WALK : pick < 80 ? CMD_UNMAP : CMD_REMAP;
      reuse_pct = (r.cmd == CMD_MAP) ? 20 : 55;
      if (live_pages.size() > 0 && $urandom_range(99) < reuse_pct)
         r.virt_page = live_pages[$urandom_range(live_pages.size() - 1)];
      else
         r.virt_page = pick_page(wide_pct);
      r.frame            = ($urandom_range(19) == 0) ? 40'd0 : 40'({$urandom, $urandom});
      r.target_virt_page = pick_page(wide_pct);
      return r;
   endfunction

   task automatic issue_item(input req_type r, input logic typed, input rsp_type typed_rsp);
      rsp_type predicted;
      int      gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      predicted = predict_page_op(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      cmd_seen[r.cmd]++;
      status_seen[predicted.status]++;
      if (predicted.status == ST_DONE && r.cmd inside {CMD_MAP, CMD_REMAP}) begin
         live_pages.push_back(r.cmd == CMD_MAP ? r.virt_page : r.target_virt_page);
         if (live_pages.size() > 64) void'(live_pages.pop_front());
      end
   endtask

   // hold the sender off until every outstanding item has answered
   task automatic drain_all();
      start <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: page %h status %0d",
                        rsp_item.result_page, rsp_item.status);
         end else begin
            oldest_rsp = pending_rsp.pop_front();
            if (rsp_item.result_page !== oldest_rsp.result_page ||
                rsp_item.status !== oldest_rsp.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected page %h status %0d, got page %h status %0d",
                           oldest_rsp.result_page, oldest_rsp.status,
                           rsp_item.result_page, rsp_item.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, pending_rsp.size());
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int lv = 0; lv < 4; lv++) begin
         hot_index[lv][0] = '0;
         hot_index[lv][1] = '1;
         hot_index[lv][2] = INDEX_W'($urandom_range(ENTRIES_PER_TABLE - 2, 1));
      end

      add_row(CMD_WALK,  '0,       '0,         '0,       1'b1, '0,         ST_NOT_PRESENT);
      add_row(CMD_UNMAP, VPN_ONES, FRAME_ONES, '0,       1'b1, '0,         ST_NOT_PRESENT);
      add_row(CMD_REMAP, '0,       '0,         VPN_ONES, 1'b1, '0,         ST_NOT_PRESENT);
      add_row(CMD_MAP,   '0,       FRAME_ONES, '0,       1'b1, '0,         ST_DONE);
      add_row(CMD_WALK,  '0,       '0,         '0,       1'b1, FRAME_ONES, ST_DONE);
      // leaf table present, entry never written
      add_row(CMD_WALK,  36'd1,    '0,         '0,       1'b1, '0,         ST_DONE);
      add_row(CMD_MAP,   VPN_ONES, '0,         VPN_ONES, 1'b1, 40'(VPN_ONES), ST_DONE);
      add_row(CMD_WALK,  VPN_ONES, FRAME_ONES, '0,       1'b1, '0,         ST_DONE);
      // frame zero counts as nothing to move
      add_row(CMD_REMAP, VPN_ONES, '0,         '0,       1'b1, '0,         ST_NOT_PRESENT);
      add_row(CMD_REMAP, '0,       '0,         '0,       1'b1, '0,         ST_DONE);
      add_row(CMD_WALK,  '0,       '0,         '0,       1'b1, FRAME_ONES, ST_DONE);
      add_row(CMD_REMAP, '0,       '0,         36'h1_2345_6789, 1'b0, '0, ST_DONE);
      add_row(CMD_WALK,  '0,       '0,         '0,       1'b0, '0,         ST_DONE);
      add_row(CMD_WALK,  36'h1_2345_6789, '0,  '0,       1'b0, '0,         ST_DONE);
      add_row(CMD_UNMAP, 36'h1_2345_6789, '0,  '0,       1'b0, '0,         ST_DONE);
      add_row(CMD_WALK,  36'h1_2345_6789, '0,  '0,       1'b0, '0,         ST_DONE);
      add_row(CMD_UNMAP, 36'h1_2345_6789, '0,  '0,       1'b0, '0,         ST_DONE);
      add_row(CMD_UNMAP, 36'h0_0000_0200, '0,  '0,       1'b1, '0,         ST_NOT_PRESENT);
      add_row(CMD_MAP,   36'h0_0000_0200, 40'hA5_5A5A_A5A5, '0, 1'b0, '0,  ST_DONE);
      add_row(CMD_REMAP, 36'h0_0000_0200, '0,  36'hA_AAAA_AAAA, 1'b0, '0,  ST_DONE);
      add_row(CMD_WALK,  36'hA_AAAA_AAAA, '0,  '0,       1'b0, '0,         ST_DONE);
      add_row(CMD_MAP,   36'h8_0000_0000, 40'h80_0000_0001, '0, 1'b0, '0,  ST_DONE);
      add_row(CMD_WALK,  36'h8_0000_0000, '0,  '0,       1'b0, '0,         ST_DONE);
      add_row(CMD_WALK,  36'h0_0000_0200, '0,  '0,       1'b0, '0,         ST_DONE);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 27;
      foreach (plan[i]) issue_item(plan[i].req, plan[i].typed, plan[i].rsp);
      drain_all();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 56 : 0;
         // last phase scatters pages widely so the table pool runs dry
         repeat (PHASE_ITEMS) issue_item(random_op(phase == 2 ? 40 : 8), 1'b0, '0);
         drain_all();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d map, %0d walk, %0d unmap, %0d remap items, %0d/%0d pages",
               cmd_seen[CMD_MAP], cmd_seen[CMD_WALK], cmd_seen[CMD_UNMAP],
               cmd_seen[CMD_REMAP], next_table, TABLE_PAGES);
      $display("Outcomes: %0d done, %0d path absent, %0d pool exhausted; %0d mismatches",
               status_seen[ST_DONE], status_seen[ST_NOT_PRESENT],
               status_seen[ST_POOL_EMPTY], mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== four_level_page_table_manager.f =====
design/fltpm_pkg.sv
design/fltpm_datapath.sv
design/fltpm_ctrl.sv
design/four_level_page_table_manager.sv
bench/tb_top.sv
